// ===== rtl/core/slid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

   localparam int DefaultDepth = 16;
   localparam int ValueWidth   = 32;
   localparam int CountWidth   = 5;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_DELETED   = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                         capture;
      logic                         ins;
      logic                         del;
      logic signed [ValueWidth-1:0] cmp_value;
      logic signed [ValueWidth-1:0] ins_value;
   } slid_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/slid_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slid_cell
   import slid_pkg::*;
(
   input  wire logic                         clock,
   input  wire slid_ctl_type                 ctl,
   input  wire logic                         occupied,
   input  wire logic                         left_le,
   input  wire logic signed [ValueWidth-1:0] left_value,
   input  wire logic signed [ValueWidth-1:0] right_value,
   output logic                              le,
   output logic                              eq,
   output logic signed [ValueWidth-1:0]      value
);

   logic signed [ValueWidth-1:0] value_ff, value_in;
   logic le_ff, le_in;
   logic lt_ff, lt_in;
   logic eq_ff, eq_in;

   always_comb begin
      le_in    = le_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      value_in = value_ff;
      if (ctl.capture) begin
         le_in = occupied && (value_ff <= ctl.cmp_value);
         lt_in = occupied && (value_ff < ctl.cmp_value);
         eq_in = occupied && (value_ff == ctl.cmp_value);
      end
      if (ctl.ins && !le_ff) begin
         // first cell above the new value takes it, the rest move up one
         value_in = left_le ? ctl.ins_value : left_value;
      end else if (ctl.del && !lt_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      le_ff    <= le_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      value_ff <= value_in;
   end

   assign le    = le_ff;
   assign eq    = eq_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_insert_delete.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted multiset of signed 32-bit values, up to DEPTH entries, kept in a
// row of cells in ascending order.
// Request channel: req_kind (0 insert, 1 delete first equal) and req_value
// are taken at a rising edge with req_start high and busy low.
// Each transaction gives one response: rsp_strobe is high for one cycle with
// rsp_status, rsp_count, rsp_smallest and rsp_smallest_valid.
// rsp_strobe is registered: busy rises at the accept edge, rsp_strobe at the
// edge that ends the busy cycle, and no request is taken while busy is high.
// In the accept cycle every cell compares its entry with req_value; in the
// next cycle (busy high) the cells from the slot up shift at once from their
// neighbors, steered by the registered flags and by full or the OR of all equal flags.
// A new request may be accepted in the cycle the response is shown.
// The receiver cannot stall: a response is presented once and not held.
// Reset clears the entry count and any pending transaction; entry contents
// are not cleared and are never read before being written.
module sorted_list_insert_delete
   import slid_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_start,
   output logic                              busy,
   input  wire logic                         req_kind,
   input  wire logic signed [ValueWidth-1:0] req_value,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [CountWidth-1:0]             rsp_count,
   output logic signed [ValueWidth-1:0]      rsp_smallest,
   output logic                              rsp_smallest_valid
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                         phase_ff, phase_in;
   logic                         kind_ff, kind_in;
   logic signed [ValueWidth-1:0] op_value_ff, op_value_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         strobe_ff, strobe_in;
   status_type                   status_ff, status_in;

   logic                         accept;
   logic                         full;
   logic                         found;
   slid_ctl_type                 ctl;
   logic [DEPTH-1:0]             le_vec;
   logic [DEPTH-1:0]             eq_vec;
   logic signed [ValueWidth-1:0] cell_value [DEPTH];

   assign accept = req_start && !phase_ff;
   assign full   = (count_ff == CW'(DEPTH));
   assign found  = |eq_vec;

   always_comb begin
      ctl.capture   = accept;
      ctl.ins       = phase_ff && !kind_ff && !full;
      ctl.del       = phase_ff && kind_ff && found;
      ctl.cmp_value = req_value;
      ctl.ins_value = op_value_ff;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         left_le;
      logic signed [ValueWidth-1:0] left_value;
      logic signed [ValueWidth-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_value = op_value_ff;
      end else begin : g_inner
         assign left_le    = le_vec[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      slid_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (CW'(i) < count_ff),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .le          (le_vec[i]),
         .eq          (eq_vec[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      op_value_in = op_value_ff;
      count_in    = count_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      if (accept) begin
         phase_in    = 1'b1;
         kind_in     = req_kind;
         op_value_in = req_value;
      end
      if (phase_ff) begin
         phase_in  = 1'b0;
         strobe_in = 1'b1;
         if (!kind_ff) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_INSERTED;
               count_in  = count_ff + CW'(1);
            end
         end else begin
            if (found) begin
               status_in = STATUS_DELETED;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= STATUS_INSERTED;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      op_value_ff <= op_value_in;
   end

   assign busy               = phase_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_count          = CountWidth'(count_ff);
   assign rsp_smallest_valid = (count_ff != '0);
   assign rsp_smallest       = rsp_smallest_valid ? cell_value[0] : '0;

endmodule

`default_nettype wire

// ===== verif/sorted_list_insert_delete_test.sv =====
`timescale 1ns / 1ps

module sorted_list_insert_delete_test;
   import slid_pkg::*;

   localparam logic OpInsert = 1'b0;
   localparam logic OpDelete = 1'b1;
   localparam int   WatchdogLimit = 2000;
   localparam int   RandomOps = 800;

   typedef struct {
      logic                         op;
      logic signed [ValueWidth-1:0] value;
      bit                           drain_first;
   } list_op_t;

   typedef struct {
      status_type                   status;
      logic [CountWidth-1:0]        count;
      logic signed [ValueWidth-1:0] smallest;
      logic                         smallest_valid;
   } list_reply_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_start = 1'b0;
   logic                         req_kind = OpInsert;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic                         busy;
   logic                         rsp_strobe;
   logic [1:0]                   rsp_status;
   logic [CountWidth-1:0]        rsp_count;
   logic signed [ValueWidth-1:0] rsp_smallest;
   logic                         rsp_smallest_valid;

   list_op_t                     pending_ops[$];
   list_reply_t                  expected_replies[$];
   logic signed [ValueWidth-1:0] shadow_list[$];

   logic took_last = 1'b0;
   int   issued = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   int   n_inserted = 0, n_full = 0, n_deleted = 0, n_missing = 0;
   int   peak_count = 0, times_emptied = 0;

   sorted_list_insert_delete dut (
      .clock              (clock),
      .reset              (reset),
      .req_start          (req_start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_count          (rsp_count),
      .rsp_smallest       (rsp_smallest),
      .rsp_smallest_valid (rsp_smallest_valid)
   );

   always #10 clock = ~clock;

   // sorted store predictor: updates the shadow list, returns the reply
   function automatic list_reply_t apply_list_op(input logic op,
                                                 input logic signed [ValueWidth-1:0] v);
      list_reply_t r;
      int          pos;
      pos = 0;
      if (op == OpInsert) begin
         if (shadow_list.size() >= DefaultDepth) begin
            r.status = STATUS_FULL;
         end else begin
            // goes after every entry <= v
            while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
            shadow_list.insert(pos, v);
            r.status = STATUS_INSERTED;
         end
      end else begin
         while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
         if (pos >= shadow_list.size()) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            shadow_list.delete(pos);
            r.status = STATUS_DELETED;
         end
      end
      r.count          = CountWidth'(shadow_list.size());
      r.smallest_valid = (shadow_list.size() > 0);
      r.smallest       = r.smallest_valid ? shadow_list[0] : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic queue_op(input logic op, input logic signed [ValueWidth-1:0] v,
                           input bit drain_first);
      list_op_t t;
      t.op          = op;
      t.value       = v;
      t.drain_first = drain_first;
      pending_ops.push_back(t);
   endtask

   // driver: changes inputs on the falling edge
   always @(negedge clock) begin : driver
      list_op_t t;
      if (reset) begin
         req_start <= 1'b0;
      end else if (req_start && !took_last) begin
         // transaction still waiting for busy to drop
      end else if (pending_ops.size() == 0) begin
         req_start <= 1'b0;
      end else if (pending_ops[0].drain_first && expected_replies.size() != 0) begin
         req_start <= 1'b0;
      end else if ((issued < 300 || issued >= 500) && $urandom_range(0, 99) < 30) begin
         req_start <= 1'b0;
      end else begin
         t = pending_ops.pop_front();
         req_kind  <= t.op;
         req_value <= t.value;
         req_start <= 1'b1;
         issued++;
      end
   end

   // monitor: samples on the rising edge, checks responses, then predicts
   always @(posedge clock) begin : monitor
      list_reply_t want;
      if (reset) begin
         took_last <= 1'b0;
      end else begin
         took_last <= req_start && !busy;
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_status, want.status.name()));
               if (rsp_count !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_count, want.count));
               if (rsp_smallest !== want.smallest)
                  report_mismatch($sformatf("smallest %0d, expected %0d",
                                            rsp_smallest, want.smallest));
               if (rsp_smallest_valid !== want.smallest_valid)
                  report_mismatch($sformatf("smallest_valid %b, expected %b",
                                            rsp_smallest_valid, want.smallest_valid));
               case (want.status)
                  STATUS_INSERTED:  n_inserted++;
                  STATUS_FULL:      n_full++;
                  STATUS_DELETED:   n_deleted++;
                  STATUS_NOT_FOUND: n_missing++;
               endcase
               if (want.count > peak_count) peak_count = want.count;
               if (want.status == STATUS_DELETED && want.count == 0) times_emptied++;
            end
         end
         if (req_start && !busy)
            expected_replies.push_back(apply_list_op(req_kind, req_value));
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_start && !busy) || rsp_strobe)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress for %0d cycles", WatchdogLimit);
            $display("sorted_list_insert_delete regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic signed [ValueWidth-1:0] recent_values[$];
      logic signed [ValueWidth-1:0] v;
      logic                         op;
      int                           insert_pct;
      int                           r;

      // directed: empty store, extremes, duplicates, fill to full, misses
      queue_op(OpDelete, 0, 1'b0);
      queue_op(OpInsert, 32'sh8000_0000, 1'b0);
      queue_op(OpInsert, 32'sh7FFF_FFFF, 1'b0);
      queue_op(OpInsert, 0, 1'b0);
      queue_op(OpInsert, -1, 1'b0);
      queue_op(OpInsert, 0, 1'b0);
      queue_op(OpDelete, 0, 1'b0);     // removes one copy only
      queue_op(OpDelete, 5, 1'b0);
      for (int i = 0; i < 12; i++) queue_op(OpInsert, i * 7 - 40, 1'b0);
      queue_op(OpInsert, 32'sh7FFF_FFFF, 1'b0);   // rejected, store full
      queue_op(OpDelete, 32'sh7FFF_FFFF, 1'b0);
      queue_op(OpDelete, 32'sh8000_0000, 1'b0);

      // random: phases lean toward insert or delete so the store swings
      // between empty and full; deletes often target values put in earlier
      insert_pct = 50;
      for (int n = 0; n < RandomOps; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpDelete;
         r  = $urandom_range(0, 99);
         if (op == OpDelete && recent_values.size() > 0 && r < 50) begin
            v = recent_values[$urandom_range(0, recent_values.size() - 1)];
         end else if (r < 60) begin
            v = int'($urandom_range(0, 8)) - 4;
         end else if (r < 75) begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh8000_0001;
               2:       v = 32'sh7FFF_FFFE;
               default: v = 32'sh7FFF_FFFF;
            endcase
         end else begin
            v = $urandom;
         end
         if (op == OpInsert) begin
            recent_values.push_back(v);
            if (recent_values.size() > 32) void'(recent_values.pop_front());
         end
         queue_op(op, v, (n % 150 == 0));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(negedge clock);
      while (pending_ops.size() != 0 || req_start || expected_replies.size() != 0);
      repeat (4) @(posedge clock);

      $display("ran %0d transactions: %0d inserts, %0d full rejects, %0d deletes, %0d misses",
               issued, n_inserted, n_full, n_deleted, n_missing);
      $display("peak occupancy %0d of %0d, store emptied by delete %0d times",
               peak_count, DefaultDepth, times_emptied);
      if (mismatch_count == 0)
         $display("sorted_list_insert_delete regression: pass");
      else
         $display("sorted_list_insert_delete regression: fail");
      $finish;
   end

endmodule
